// ----- rtl/core/bls_pkg.sv -----
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int COORD_BITS_DEFAULT = 12;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // Octant mapping of a line, produced at setup and held by the stepper.
    typedef struct packed {
        logic swap_axes;
        logic negate_x;
        logic negate_y;
    } line_flags_t;

    // Status bits that travel with each emitted pixel.
    typedef struct packed {
        logic last;
        logic idle;
    } pixel_flags_t;

endpackage

// ----- rtl/core/bls_line_setup.sv -----
// ----------------------------------------------------------------------------
// bls_line_setup
// Derives major and minor lengths, octant flags, increments and the initial
// decision term from the two endpoints of a line.
// ----------------------------------------------------------------------------
module bls_line_setup
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output line_flags_t                  flags,
    output logic        [COORD_BITS-1:0] major_len,
    output logic        [COORD_BITS:0]   inc_straight,
    output logic signed [COORD_BITS+1:0] inc_diagonal,
    output logic signed [COORD_BITS+2:0] decision_init
);

    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic        [COORD_BITS:0]   abs_x_full;
    logic        [COORD_BITS:0]   abs_y_full;
    logic        [COORD_BITS-1:0] abs_x;
    logic        [COORD_BITS-1:0] abs_y;
    logic        [COORD_BITS-1:0] minor_len;
    logic                         swap;

    assign dx = $signed({x_end[COORD_BITS-1], x_end})
              - $signed({x_start[COORD_BITS-1], x_start});
    assign dy = $signed({y_end[COORD_BITS-1], y_end})
              - $signed({y_start[COORD_BITS-1], y_start});

    // A difference of two coordinates has a magnitude below 2**COORD_BITS.
    assign abs_x_full = dx[COORD_BITS] ? (-dx) : dx;
    assign abs_y_full = dy[COORD_BITS] ? (-dy) : dy;
    assign abs_x      = abs_x_full[COORD_BITS-1:0];
    assign abs_y      = abs_y_full[COORD_BITS-1:0];

    assign swap      = abs_y > abs_x;
    assign major_len = swap ? abs_y : abs_x;
    assign minor_len = swap ? abs_x : abs_y;

    assign flags.swap_axes = swap;
    assign flags.negate_x  = dx[COORD_BITS];
    assign flags.negate_y  = dy[COORD_BITS];

    assign inc_straight  = {minor_len, 1'b0};
    assign inc_diagonal  = $signed({1'b0, minor_len, 1'b0})
                         - $signed({1'b0, major_len, 1'b0});
    assign decision_init = $signed({2'b00, minor_len, 1'b0})
                         - $signed({3'b000, major_len});

endmodule

// ----- rtl/core/bls_stepper.sv -----
// ----------------------------------------------------------------------------
// bls_stepper
// Line state registers and the per-pixel step: decision update, offset
// advance and mapping of the offsets back to screen coordinates.
// ----------------------------------------------------------------------------
module bls_stepper
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  logic                         mode,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  line_flags_t                  setup_flags,
    input  logic        [COORD_BITS-1:0] setup_major_len,
    input  logic        [COORD_BITS:0]   setup_inc_straight,
    input  logic signed [COORD_BITS+1:0] setup_inc_diagonal,
    input  logic signed [COORD_BITS+2:0] setup_decision,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output pixel_flags_t                 pixel_flags
);

    logic                         active_reg,       active_next;
    logic signed [COORD_BITS+2:0] decision_reg,     decision_next;
    logic        [COORD_BITS-1:0] major_pos_reg,    major_pos_next;
    logic        [COORD_BITS-1:0] minor_pos_reg,    minor_pos_next;
    logic        [COORD_BITS-1:0] major_len_reg,    major_len_next;
    logic        [COORD_BITS:0]   inc_straight_reg, inc_straight_next;
    logic signed [COORD_BITS+1:0] inc_diagonal_reg, inc_diagonal_next;
    line_flags_t                  flags_reg,        flags_next;
    logic        [COORD_BITS-1:0] origin_x_reg,     origin_x_next;
    logic        [COORD_BITS-1:0] origin_y_reg,     origin_y_next;

    logic                         go_straight;
    logic        [COORD_BITS-1:0] major_step;
    logic        [COORD_BITS-1:0] minor_step;
    logic                         step_done;
    logic        [COORD_BITS-1:0] off_x;
    logic        [COORD_BITS-1:0] off_y;
    logic        [COORD_BITS-1:0] step_x;
    logic        [COORD_BITS-1:0] step_y;

    // A negative decision term keeps the minor axis where it is.
    assign go_straight = decision_reg[COORD_BITS+2];
    assign major_step  = major_pos_reg + COORD_BITS'(1);
    assign minor_step  = minor_pos_reg + {{(COORD_BITS-1){1'b0}}, ~go_straight};
    assign step_done   = major_step >= major_len_reg;

    assign off_x  = flags_reg.swap_axes ? minor_step : major_step;
    assign off_y  = flags_reg.swap_axes ? major_step : minor_step;
    assign step_x = origin_x_reg + (flags_reg.negate_x ? (-off_x) : off_x);
    assign step_y = origin_y_reg + (flags_reg.negate_y ? (-off_y) : off_y);

    always_comb begin
        active_next       = active_reg;
        decision_next     = decision_reg;
        major_pos_next    = major_pos_reg;
        minor_pos_next    = minor_pos_reg;
        major_len_next    = major_len_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        flags_next        = flags_reg;
        origin_x_next     = origin_x_reg;
        origin_y_next     = origin_y_reg;
        pixel_x           = '0;
        pixel_y           = '0;
        pixel_flags       = '{last: 1'b0, idle: 1'b0};

        if (mode == MODE_START) begin
            pixel_x          = x_start;
            pixel_y          = y_start;
            pixel_flags.last = (setup_major_len == '0);
            if (fire) begin
                active_next       = (setup_major_len != '0);
                decision_next     = setup_decision;
                major_pos_next    = '0;
                minor_pos_next    = '0;
                major_len_next    = setup_major_len;
                inc_straight_next = setup_inc_straight;
                inc_diagonal_next = setup_inc_diagonal;
                flags_next        = setup_flags;
                origin_x_next     = x_start;
                origin_y_next     = y_start;
            end
        end else if (!active_reg) begin
            pixel_flags.idle = 1'b1;
        end else begin
            pixel_x          = step_x;
            pixel_y          = step_y;
            pixel_flags.last = step_done;
            if (fire) begin
                active_next    = ~step_done;
                decision_next  = go_straight
                               ? decision_reg + $signed({2'b00, inc_straight_reg})
                               : decision_reg + (COORD_BITS+3)'(inc_diagonal_reg);
                major_pos_next = major_step;
                minor_pos_next = minor_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg       <= 1'b0;
            decision_reg     <= '0;
            major_pos_reg    <= '0;
            minor_pos_reg    <= '0;
            major_len_reg    <= '0;
            inc_straight_reg <= '0;
            inc_diagonal_reg <= '0;
            flags_reg        <= '0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
        end else begin
            active_reg       <= active_next;
            decision_reg     <= decision_next;
            major_pos_reg    <= major_pos_next;
            minor_pos_reg    <= minor_pos_next;
            major_len_reg    <= major_len_next;
            inc_straight_reg <= inc_straight_next;
            inc_diagonal_reg <= inc_diagonal_next;
            flags_reg        <= flags_next;
            origin_x_reg     <= origin_x_next;
            origin_y_reg     <= origin_y_next;
        end
    end

endmodule

// ----- rtl/core/bresenham_line_stepper_unit.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_stepper_unit
// All-octant Bresenham line rasterizer that emits one pixel per input beat.
// ----------------------------------------------------------------------------
// Usage: the s_ channel carries one command per beat. A start beat (mode 0)
// loads both endpoints and returns the start point; each step beat (mode 1)
// returns the next pixel of the line, with m_last set on the end point.
// A step with no line in progress returns a beat with m_idle set and zero
// coordinates. A start beat may be sent at any time and drops the old line.
// Path: a beat accepted on the s_ channel passes through the input register,
// then the result register, before it appears on the m_ channel.
// Throughput: one beat per clock while m_ready is high; the line state is
// updated in the cycle the result register loads, so steps run back to back.
// Stall: while m_ready is low the result holds, the input register can still
// fill, and s_ready falls only once both registers are full.
// Reset: aresetn (synchronous, active low) empties both registers and clears
// the line state, so the first step after reset reports idle.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_unit
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic signed [COORD_BITS-1:0] s_x_start,
    input  logic signed [COORD_BITS-1:0] s_y_start,
    input  logic signed [COORD_BITS-1:0] s_x_end,
    input  logic signed [COORD_BITS-1:0] s_y_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_pixel_x,
    output logic signed [COORD_BITS-1:0] m_pixel_y,
    output logic                         m_last,
    output logic                         m_idle
);

    logic                         in_valid_reg;
    logic                         in_mode_reg;
    logic signed [COORD_BITS-1:0] in_x_start_reg;
    logic signed [COORD_BITS-1:0] in_y_start_reg;
    logic signed [COORD_BITS-1:0] in_x_end_reg;
    logic signed [COORD_BITS-1:0] in_y_end_reg;

    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    pixel_flags_t                 out_flags_reg;

    logic                         advance;
    logic                         fire;

    line_flags_t                  setup_flags;
    logic        [COORD_BITS-1:0] setup_major_len;
    logic        [COORD_BITS:0]   setup_inc_straight;
    logic signed [COORD_BITS+1:0] setup_inc_diagonal;
    logic signed [COORD_BITS+2:0] setup_decision;

    logic signed [COORD_BITS-1:0] pix_x;
    logic signed [COORD_BITS-1:0] pix_y;
    pixel_flags_t                 pix_flags;

    assign advance = ~out_valid_reg | m_ready;
    assign fire    = in_valid_reg & advance;
    assign s_ready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_mode_reg    <= s_mode;
            in_x_start_reg <= s_x_start;
            in_y_start_reg <= s_y_start;
            in_x_end_reg   <= s_x_end;
            in_y_end_reg   <= s_y_end;
        end
    end

    bls_line_setup #(
        .COORD_BITS(COORD_BITS)
    ) u_setup (
        .x_start      (in_x_start_reg),
        .y_start      (in_y_start_reg),
        .x_end        (in_x_end_reg),
        .y_end        (in_y_end_reg),
        .flags        (setup_flags),
        .major_len    (setup_major_len),
        .inc_straight (setup_inc_straight),
        .inc_diagonal (setup_inc_diagonal),
        .decision_init(setup_decision)
    );

    bls_stepper #(
        .COORD_BITS(COORD_BITS)
    ) u_stepper (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .fire              (fire),
        .mode              (in_mode_reg),
        .x_start           (in_x_start_reg),
        .y_start           (in_y_start_reg),
        .setup_flags       (setup_flags),
        .setup_major_len   (setup_major_len),
        .setup_inc_straight(setup_inc_straight),
        .setup_inc_diagonal(setup_inc_diagonal),
        .setup_decision    (setup_decision),
        .pixel_x           (pix_x),
        .pixel_y           (pix_y),
        .pixel_flags       (pix_flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_x_reg     <= pix_x;
            out_y_reg     <= pix_y;
            out_flags_reg <= pix_flags;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_pixel_x = out_x_reg;
    assign m_pixel_y = out_y_reg;
    assign m_last    = out_flags_reg.last;
    assign m_idle    = out_flags_reg.idle;

endmodule

// ----- rtl/core/bls_checker.sv -----
// ----------------------------------------------------------------------------
// bls_checker
// Port-level assertions for the Bresenham line stepper, bound to the top.
// ----------------------------------------------------------------------------
module bls_checker
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [COORD_BITS-1:0] m_pixel_x,
    input logic signed [COORD_BITS-1:0] m_pixel_y,
    input logic                         m_last,
    input logic                         m_idle
);

    // Nothing may be presented in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    // An idle beat carries no pixel.
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_idle) |-> (m_pixel_x == '0 && m_pixel_y == '0 && !m_last))
        else $error("idle beat with pixel data or last set");

    // The block has two beats of storage, so a single stalled result never
    // blocks the input side.
    a_ready_one_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid) |-> s_ready)
        else $error("input stalled with result register empty");

    // A stalled result beat holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pixel_x)
            && $stable(m_pixel_y) && $stable(m_last) && $stable(m_idle)))
        else $error("stalled result beat changed");

endmodule

bind bresenham_line_stepper_unit bls_checker #(
    .COORD_BITS(COORD_BITS)
) u_bls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_pixel_x(m_pixel_x),
    .m_pixel_y(m_pixel_y),
    .m_last   (m_last),
    .m_idle   (m_idle)
);

// ----- tb/sv/line_pixel_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_pixel_checker
// Watches both channels of the line stepper, keeps its own copy of the line
// state, predicts the pixel for every accepted command beat and compares each
// result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module line_pixel_checker
    import bls_pkg::*;
#(
    parameter int CB = COORD_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_mode,
    input  logic signed [CB-1:0] s_x_start,
    input  logic signed [CB-1:0] s_y_start,
    input  logic signed [CB-1:0] s_x_end,
    input  logic signed [CB-1:0] s_y_end,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic signed [CB-1:0] m_pixel_x,
    input  logic signed [CB-1:0] m_pixel_y,
    input  logic                 m_last,
    input  logic                 m_idle,
    output int                   mismatch_count,
    output int                   pixels_pending
);

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        pixel_flags_t         flags;
    } pixel_t;

    pixel_t expected_pixels[$];

    // Line state, held at the block's own widths.
    logic                 line_active = 1'b0;
    logic signed [CB+2:0] decision_term = '0;
    logic [CB-1:0]        major_step = '0;
    logic [CB-1:0]        minor_step = '0;
    logic [CB-1:0]        major_span = '0;
    logic [CB:0]          straight_inc = '0;
    logic signed [CB+1:0] diagonal_inc = '0;
    line_flags_t          octant = '0;
    logic signed [CB-1:0] origin_x = '0;
    logic signed [CB-1:0] origin_y = '0;

    initial begin
        mismatch_count = 0;
        pixels_pending = 0;
    end

    // Maps the major/minor offsets back into screen space.
    function automatic pixel_t place_pixel(input logic is_last);
        int     ox;
        int     oy;
        int     px;
        int     py;
        pixel_t p;
        ox = octant.swap_axes ? int'(minor_step) : int'(major_step);
        oy = octant.swap_axes ? int'(major_step) : int'(minor_step);
        px = int'(origin_x) + (octant.negate_x ? -ox : ox);
        py = int'(origin_y) + (octant.negate_y ? -oy : oy);
        p.x = px[CB-1:0];
        p.y = py[CB-1:0];
        p.flags.last = is_last;
        p.flags.idle = 1'b0;
        return p;
    endfunction

    task automatic advance_line(input logic mode, input logic signed [CB-1:0] xs,
                                input logic signed [CB-1:0] ys,
                                input logic signed [CB-1:0] xe,
                                input logic signed [CB-1:0] ye);
        int     dx;
        int     dy;
        int     ax;
        int     ay;
        int     major;
        int     minor;
        pixel_t p;
        if (mode == MODE_START) begin
            dx = int'(xe) - int'(xs);
            dy = int'(ye) - int'(ys);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            octant.negate_x = (dx < 0);
            octant.negate_y = (dy < 0);
            // Equal deltas keep x as the major axis.
            octant.swap_axes = (ay > ax);
            major = octant.swap_axes ? ay : ax;
            minor = octant.swap_axes ? ax : ay;
            major_span = CB'(major);
            straight_inc = (CB+1)'(2 * minor);
            diagonal_inc = (CB+2)'(2 * (minor - major));
            decision_term = (CB+3)'(2 * minor - major);
            major_step = '0;
            minor_step = '0;
            origin_x = xs;
            origin_y = ys;
            line_active = (major != 0);
            p = place_pixel(major == 0);
        end else if (!line_active) begin
            p = '{x: '0, y: '0, flags: '{last: 1'b0, idle: 1'b1}};
        end else begin
            if (decision_term < 0) begin
                decision_term = decision_term + $signed({2'b00, straight_inc});
            end else begin
                decision_term = decision_term + diagonal_inc;
                minor_step = minor_step + CB'(1);
            end
            major_step = major_step + CB'(1);
            if (major_step >= major_span) begin
                line_active = 1'b0;
                p = place_pixel(1'b1);
            end else begin
                p = place_pixel(1'b0);
            end
        end
        expected_pixels.insert(expected_pixels.size(), p);
    endtask

    always @(posedge aclk) begin : watch
        pixel_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                advance_line(s_mode, s_x_start, s_y_start, s_x_end, s_y_end);
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%t: unexpected pixel beat x=%0d y=%0d last=%0b idle=%0b",
                                 $time, m_pixel_x, m_pixel_y, m_last, m_idle);
                    end
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_pixel_x !== want.x || m_pixel_y !== want.y ||
                        m_last !== want.flags.last || m_idle !== want.flags.idle) begin
                        if (mismatch_count < 10) begin
                            $display("%t: pixel mismatch: expected x=%0d y=%0d last=%0b idle=%0b",
                                     $time, want.x, want.y, want.flags.last, want.flags.idle);
                            $display("%t:                   got x=%0d y=%0d last=%0b idle=%0b",
                                     $time, m_pixel_x, m_pixel_y, m_last, m_idle);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            pixels_pending <= expected_pixels.size();
        end
    end

endmodule

// ----- tb/sv/bresenham_line_stepper_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bresenham_line_stepper_unit_test
// Drives the line stepper with directed lines across the octants and the
// coordinate extremes, then with random lines traced to their end, cut short
// or interleaved with stray commands, under three idling patterns. A checker
// beside the block predicts and compares every pixel beat.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_unit_test;
    import bls_pkg::*;

    localparam int CB = COORD_BITS_DEFAULT;
    localparam int STALL_LIMIT = 2000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_mode = MODE_START;
    logic signed [CB-1:0] s_x_start = '0;
    logic signed [CB-1:0] s_y_start = '0;
    logic signed [CB-1:0] s_x_end = '0;
    logic signed [CB-1:0] s_y_end = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [CB-1:0] m_pixel_x;
    logic signed [CB-1:0] m_pixel_y;
    logic                 m_last;
    logic                 m_idle;

    int mismatch_count;
    int pixels_pending;
    int tx_idle_pct = 22;
    int rx_idle_pct = 68;
    int beats_sent = 0;
    int quiet_cycles = 0;

    bresenham_line_stepper_unit #(
        .COORD_BITS(CB)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(s_mode),
        .s_x_start(s_x_start),
        .s_y_start(s_y_start),
        .s_x_end(s_x_end),
        .s_y_end(s_y_end),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pixel_x(m_pixel_x),
        .m_pixel_y(m_pixel_y),
        .m_last(m_last),
        .m_idle(m_idle)
    );

    line_pixel_checker #(
        .CB(CB)
    ) checker_i (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(s_mode),
        .s_x_start(s_x_start),
        .s_y_start(s_y_start),
        .s_x_end(s_x_end),
        .s_y_end(s_y_end),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pixel_x(m_pixel_x),
        .m_pixel_y(m_pixel_y),
        .m_last(m_last),
        .m_idle(m_idle),
        .mismatch_count(mismatch_count),
        .pixels_pending(pixels_pending)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Ends the run when neither channel has moved a beat for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("bresenham_line_stepper_unit_test failed");
                $finish;
            end
        end
    end

    function automatic logic [CB-1:0] any_coord();
        return CB'($urandom);
    endfunction

    task automatic send_beat(input logic mode, input logic [CB-1:0] xs,
                             input logic [CB-1:0] ys, input logic [CB-1:0] xe,
                             input logic [CB-1:0] ye);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_x_start <= xs;
        s_y_start <= ys;
        s_x_end <= xe;
        s_y_end <= ye;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic start_line(input int xs, input int ys, input int xe, input int ye);
        send_beat(MODE_START, CB'(xs), CB'(ys), CB'(xe), CB'(ye));
    endtask

    // Endpoint fields are don't-care on a step, so they carry noise.
    task automatic step_line(input int count);
        repeat (count) send_beat(MODE_STEP, any_coord(), any_coord(), any_coord(), any_coord());
    endtask

    // Keeps the end point on screen by mirroring the delta when needed.
    function automatic int fit_delta(input int origin, input int delta);
        if (origin + delta > 2047 || origin + delta < -2048) begin
            return -delta;
        end
        return delta;
    endfunction

    task automatic draw_random_line();
        int pick;
        int span;
        int xs;
        int ys;
        int dx;
        int dy;
        int major;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_beat(1'($urandom_range(1)), any_coord(), any_coord(), any_coord(),
                      any_coord());
        end else begin
            xs = int'($urandom_range(4095)) - 2048;
            ys = int'($urandom_range(4095)) - 2048;
            if (pick < 80) begin
                span = 12;
            end else if (pick < 96) begin
                span = 150;
            end else begin
                span = 2047;
            end
            dx = fit_delta(xs, int'($urandom_range(2 * span)) - span);
            dy = fit_delta(ys, int'($urandom_range(2 * span)) - span);
            if ($urandom_range(9) == 0) begin
                dy = fit_delta(ys, ($urandom_range(1) != 0) ? dx : -dx);
            end
            major = (dx < 0 ? -dx : dx);
            if ((dy < 0 ? -dy : dy) > major) begin
                major = (dy < 0 ? -dy : dy);
            end
            start_line(xs, ys, xs + dx, ys + dy);
            if (span == 2047) begin
                step_line($urandom_range(20, 1));
            end else if ($urandom_range(99) < 85) begin
                step_line(major + $urandom_range(2));
            end else begin
                step_line($urandom_range(major));
            end
        end
    endtask

    task automatic run_random_lines(input int target);
        while (beats_sent < target) draw_random_line();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Step with no line after reset.
        send_beat(MODE_STEP, '1, '1, '1, '1);
        // Single-point line, then a step that must report idle.
        start_line(5, 5, 5, 5);
        step_line(1);
        // Full-scale diagonal, abandoned by a restart in the opposite direction.
        start_line(-2048, -2048, 2047, 2047);
        step_line(2);
        start_line(2047, 2047, -2048, -2048);
        step_line(1);
        // Shallow line traced past its end.
        start_line(0, 0, 5, 2);
        step_line(6);
        // Steep line with the x axis negated.
        start_line(10, -2048, 7, 2047);
        step_line(2);
        start_line(2047, 0, -2048, 3);
        step_line(1);
        start_line(0, 0, -1, -1);
        step_line(1);
        // Vertical line going up the screen.
        start_line(3, 3, 3, -4);
        step_line(2);

        run_random_lines(450);
        tx_idle_pct <= 68;
        rx_idle_pct <= 22;
        run_random_lines(880);
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        run_random_lines(1300);
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pixels_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pixels_pending == 0) begin
            $display("bresenham_line_stepper_unit_test passed");
        end else begin
            $display("bresenham_line_stepper_unit_test failed");
        end
        $finish;
    end

endmodule
